### hdl/imgup_pkg.sv
// Shared constants and codes of the image upscale interpolator.
package imgup_pkg;

    // Frame store and arithmetic sizes
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIXEL_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // Field and register widths
    localparam int COORD_BITS    = 12;
    localparam int SIZE_BITS     = 9;
    localparam int DST_BITS      = 12;
    localparam int STEP_BITS     = 17;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;

    // Derived widths
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int BANK_AW    = (XW - 1) + (YW - 1);
    localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 4;
    localparam int POS_BITS   = COORD_BITS + STEP_BITS;
    localparam int INT_BITS   = POS_BITS - FRAC_BITS;
    localparam int WGT_BITS   = FRAC_BITS + 1;
    localparam int ROW_BITS   = PIXEL_BITS + FRAC_BITS;
    localparam int PROD_BITS  = ROW_BITS + WGT_BITS;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_X     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_Y     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERP     = 3'd6;

    // Opcodes and modes
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_REQUEST   = 1'b1;
    localparam logic MODE_NEAREST = 1'b0;
    localparam logic MODE_BILIN   = 1'b1;

    // Control that travels with each beat
    typedef struct packed {
        logic op;
        logic cov;
    } t_ctl;

endpackage

### hdl/imgup_in_if.sv
// Input channel: write or request beats.
interface imgup_in_if;
    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic [imgup_pkg::COORD_BITS-1:0]   col;
    logic [imgup_pkg::COORD_BITS-1:0]   row;
    logic [imgup_pkg::PIXEL_BITS-1:0]   pixel_in;

    modport source(output valid, opcode, col, row, pixel_in, input ready);
    modport sink(input valid, opcode, col, row, pixel_in, output ready);
endinterface

### hdl/imgup_out_if.sv
// Output channel: one result beat per input beat.
interface imgup_out_if;
    logic                               valid;
    logic                               ready;
    logic                               op_echo;
    logic [imgup_pkg::PIXEL_BITS-1:0]   pixel_out;
    logic                               covered;

    modport source(output valid, op_echo, pixel_out, covered, input ready);
    modport sink(input valid, op_echo, pixel_out, covered, output ready);
endinterface

### hdl/imgup_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imgup_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/image_upscale_interpolator.sv
// Top level of the image upscale interpolator: banked frame store and interpolation pipeline.
//
//  Channel   Dir  Handshake      Beat contents
//  i_in      in   valid/ready    opcode, col, row, pixel_in
//  o_out     out  valid/ready    op_echo, pixel_out, covered
//  i_cfg_*   in   write enable   register index, data
//
// One beat enters per cycle while the output is not stalled; o_out.valid rises once the beat reaches the last stage.
// The frame store is four parity banks, so the four neighbours are read in the same cycle.
// Seven register stages advance together; a stalled output holds every stage and
// drops i_in.ready, so no beat is lost or repeated. The frame store needs no clearing.
// Reset is synchronous, active low, clears valid bits and loads the default configuration.
module image_upscale_interpolator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    imgup_in_if.sink                             i_in,
    imgup_out_if.source                          o_out,
    input  logic                                 i_cfg_we,
    input  logic [imgup_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [imgup_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    localparam int CW  = imgup_pkg::COORD_BITS;
    localparam int PW  = imgup_pkg::PIXEL_BITS;
    localparam int FB  = imgup_pkg::FRAC_BITS;
    localparam int XW  = imgup_pkg::XW;
    localparam int YW  = imgup_pkg::YW;
    localparam int AW  = imgup_pkg::BANK_AW;
    localparam int SB  = imgup_pkg::SIZE_BITS;
    localparam int DB  = imgup_pkg::DST_BITS;
    localparam int STB = imgup_pkg::STEP_BITS;
    localparam int PSB = imgup_pkg::POS_BITS;
    localparam int IB  = imgup_pkg::INT_BITS;
    localparam int WB  = imgup_pkg::WGT_BITS;
    localparam int RB  = imgup_pkg::ROW_BITS;
    localparam int MB  = imgup_pkg::PROD_BITS;

    // Configuration registers
    logic [SB-1:0]  r_src_width, r_src_height;
    logic [DB-1:0]  r_dst_width, r_dst_height;
    logic [STB-1:0] r_step_x, r_step_y;
    logic           r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SB'(256);
            r_src_height <= SB'(256);
            r_dst_width  <= DB'(256);
            r_dst_height <= DB'(256);
            r_step_x     <= STB'(65536);
            r_step_y     <= STB'(65536);
            r_mode       <= imgup_pkg::MODE_BILIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                imgup_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[SB-1:0];
                imgup_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[SB-1:0];
                imgup_pkg::CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[DB-1:0];
                imgup_pkg::CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[DB-1:0];
                imgup_pkg::CFG_STEP_X:     r_step_x     <= i_cfg_data[STB-1:0];
                imgup_pkg::CFG_STEP_Y:     r_step_y     <= i_cfg_data[STB-1:0];
                imgup_pkg::CFG_INTERP:     r_mode       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective source size: zero acts as one, oversize clamps to the store
    logic [SB-1:0] w_sw, w_sh;
    always_comb begin
        w_sw = r_src_width;
        if (r_src_width == '0) w_sw = SB'(1);
        else if (r_src_width > SB'(imgup_pkg::MAX_WIDTH)) w_sw = SB'(imgup_pkg::MAX_WIDTH);
        w_sh = r_src_height;
        if (r_src_height == '0) w_sh = SB'(1);
        else if (r_src_height > SB'(imgup_pkg::MAX_HEIGHT)) w_sh = SB'(imgup_pkg::MAX_HEIGHT);
    end

    // Global advance: every stage moves when the output register can drain
    logic w_adv;
    logic [7:1] r_v;
    assign w_adv = !r_v[7] || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[6:1], i_in.valid};
        end
    end

    // Stage 1: capture the input beat
    logic          r_s1_op;
    logic [CW-1:0] r_s1_col, r_s1_row;
    logic [PW-1:0] r_s1_pix;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_op  <= i_in.opcode;
            r_s1_col <= i_in.col;
            r_s1_row <= i_in.row;
            r_s1_pix <= i_in.pixel_in;
        end
    end

    // Stage 2: source positions and destination bounds
    logic           r_s2_op, r_s2_dok;
    logic [PSB-1:0] r_s2_px, r_s2_py;
    logic [CW-1:0]  r_s2_col, r_s2_row;
    logic [PW-1:0]  r_s2_pix;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_op  <= r_s1_op;
            r_s2_px  <= PSB'(r_s1_col) * PSB'(r_step_x);
            r_s2_py  <= PSB'(r_s1_row) * PSB'(r_step_y);
            r_s2_dok <= (DB'(r_s1_col) < r_dst_width) && (DB'(r_s1_row) < r_dst_height);
            r_s2_col <= r_s1_col;
            r_s2_row <= r_s1_row;
            r_s2_pix <= r_s1_pix;
        end
    end

    // Stage 2 logic: integer parts, rounding, clamp, neighbour check
    logic [IB-1:0]  w_xi, w_yi;
    logic [IB:0]    w_xn, w_yn;
    logic [PSB:0]   w_xr, w_yr;
    logic [XW-1:0]  w_xnc, w_cx;
    logic [YW-1:0]  w_ync, w_cy;
    logic           w_bok, w_nearest, w_cov;
    logic [FB-1:0]  w_fx, w_fy;
    logic [AW-1:0]  w_raddr [4];
    logic [XW-1:0]  w_csel  [4];
    logic [YW-1:0]  w_rsel  [4];

    always_comb begin
        w_nearest = (r_mode == imgup_pkg::MODE_NEAREST);
        w_xi = r_s2_px[PSB-1:FB];
        w_yi = r_s2_py[PSB-1:FB];
        w_xr = (PSB+1)'(r_s2_px) + (PSB+1)'(1 << (FB - 1));
        w_yr = (PSB+1)'(r_s2_py) + (PSB+1)'(1 << (FB - 1));
        w_xn = w_xr[PSB:FB];
        w_yn = w_yr[PSB:FB];
        w_xnc = (w_xn >= (IB+1)'(w_sw)) ? XW'(w_sw - 1'b1) : w_xn[XW-1:0];
        w_ync = (w_yn >= (IB+1)'(w_sh)) ? YW'(w_sh - 1'b1) : w_yn[YW-1:0];
        w_bok = (((IB+1)'(w_xi) + 1'b1) < (IB+1)'(w_sw)) &&
                (((IB+1)'(w_yi) + 1'b1) < (IB+1)'(w_sh));
        w_cx = w_nearest ? w_xnc : w_xi[XW-1:0];
        w_cy = w_nearest ? w_ync : w_yi[YW-1:0];
        w_fx = w_nearest ? '0 : r_s2_px[FB-1:0];
        w_fy = w_nearest ? '0 : r_s2_py[FB-1:0];
        w_cov = (r_s2_op == imgup_pkg::OP_REQUEST) && r_s2_dok && (w_nearest || w_bok);
        // Each bank holds one row parity and one column parity
        for (int b = 0; b < 4; b++) begin
            w_csel[b] = (w_cx[0] == b[0]) ? w_cx : w_cx + 1'b1;
            w_rsel[b] = (w_cy[0] == b[1]) ? w_cy : w_cy + 1'b1;
            w_raddr[b] = {w_rsel[b][YW-1:1], w_csel[b][XW-1:1]};
        end
    end

    // Stage 3: bank addresses and write port
    imgup_pkg::t_ctl r_s3_ctl;
    logic           r_s3_near, r_s3_xp, r_s3_yp, r_s3_wen;
    logic [FB-1:0]  r_s3_fx, r_s3_fy;
    logic [AW-1:0]  r_s3_raddr [4];
    logic [AW-1:0]  r_s3_waddr;
    logic [1:0]     r_s3_wbank;
    logic [PW-1:0]  r_s3_wdata;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_ctl.op  <= r_s2_op;
            r_s3_ctl.cov <= w_cov;
            r_s3_near    <= w_nearest;
            r_s3_xp      <= w_cx[0];
            r_s3_yp      <= w_cy[0];
            r_s3_fx      <= w_fx;
            r_s3_fy      <= w_fy;
            for (int b = 0; b < 4; b++) begin
                r_s3_raddr[b] <= w_raddr[b];
            end
            r_s3_wen   <= (r_s2_op == imgup_pkg::OP_WRITE) &&
                          (r_s2_col < CW'(imgup_pkg::MAX_WIDTH)) &&
                          (r_s2_row < CW'(imgup_pkg::MAX_HEIGHT));
            r_s3_wbank <= {r_s2_row[0], r_s2_col[0]};
            r_s3_waddr <= {r_s2_row[YW-1:1], r_s2_col[XW-1:1]};
            r_s3_wdata <= r_s2_pix;
        end
    end

    // Frame store banks, read data lands in stage 4
    logic [PW-1:0] w_rd [4];
    for (genvar g = 0; g < 4; g++) begin : g_bank
        imgup_ram #(.WIDTH(PW), .DEPTH(imgup_pkg::BANK_DEPTH)) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_adv && r_v[3] && r_s3_wen && (r_s3_wbank == 2'(g))),
            .i_waddr (r_s3_waddr),
            .i_wdata (r_s3_wdata),
            .i_re    (w_adv),
            .i_raddr (r_s3_raddr[g]),
            .o_rdata (w_rd[g])
        );
    end

    // Stage 4: control alongside the bank read data
    imgup_pkg::t_ctl r_s4_ctl;
    logic           r_s4_near, r_s4_xp, r_s4_yp;
    logic [FB-1:0]  r_s4_fx, r_s4_fy;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_ctl  <= r_s3_ctl;
            r_s4_near <= r_s3_near;
            r_s4_xp   <= r_s3_xp;
            r_s4_yp   <= r_s3_yp;
            r_s4_fx   <= r_s3_fx;
            r_s4_fy   <= r_s3_fy;
        end
    end

    // Route banks to neighbours; nearest keeps only the base pixel
    logic [PW-1:0] w_p00, w_p01, w_p10, w_p11;
    logic [WB-1:0] w_wx1, w_wx0;
    always_comb begin
        w_p00 = w_rd[{r_s4_yp, r_s4_xp}];
        w_p01 = r_s4_near ? '0 : w_rd[{r_s4_yp, !r_s4_xp}];
        w_p10 = r_s4_near ? '0 : w_rd[{!r_s4_yp, r_s4_xp}];
        w_p11 = r_s4_near ? '0 : w_rd[{!r_s4_yp, !r_s4_xp}];
        w_wx1 = WB'(r_s4_fx);
        w_wx0 = WB'(1 << FB) - w_wx1;
    end

    // Stage 5: horizontal blends
    imgup_pkg::t_ctl r_s5_ctl;
    logic [FB-1:0]  r_s5_fy;
    logic [RB-1:0]  r_s5_top, r_s5_bot;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_ctl <= r_s4_ctl;
            r_s5_fy  <= r_s4_fy;
            r_s5_top <= RB'(RB'(w_p00) * RB'(w_wx0) + RB'(w_p01) * RB'(w_wx1));
            r_s5_bot <= RB'(RB'(w_p10) * RB'(w_wx0) + RB'(w_p11) * RB'(w_wx1));
        end
    end

    // Stage 6: vertical weights
    imgup_pkg::t_ctl r_s6_ctl;
    logic [MB-1:0]  r_s6_m0, r_s6_m1;
    logic [WB-1:0]  w_wy1, w_wy0;
    assign w_wy1 = WB'(r_s5_fy);
    assign w_wy0 = WB'(1 << FB) - w_wy1;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s6_ctl <= r_s5_ctl;
            r_s6_m0  <= MB'(r_s5_top) * MB'(w_wy0);
            r_s6_m1  <= MB'(r_s5_bot) * MB'(w_wy1);
        end
    end

    // Stage 7: sum, round half up, gate uncovered beats
    logic [MB-1:0] w_sum;
    assign w_sum = r_s6_m0 + r_s6_m1 + MB'(1) * (MB'(1) << (2 * FB - 1));

    logic          r_s7_op, r_s7_cov;
    logic [PW-1:0] r_s7_pix;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s7_op  <= r_s6_ctl.op;
            r_s7_cov <= r_s6_ctl.cov;
            r_s7_pix <= r_s6_ctl.cov ? w_sum[2*FB+PW-1:2*FB] : '0;
        end
    end

    assign o_out.valid     = r_v[7];
    assign o_out.op_echo   = r_s7_op;
    assign o_out.covered   = r_s7_cov;
    assign o_out.pixel_out = r_s7_pix;

    // Uncovered results carry a zero pixel
    a_uncov_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.covered) |-> (o_out.pixel_out == '0))
        else $error("uncovered result with nonzero pixel");

    // Only requests can be covered
    a_cov_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.covered) |-> (o_out.op_echo == imgup_pkg::OP_REQUEST))
        else $error("covered result for a write beat");

    // A stalled output blocks new input beats
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while output stalled");

    // A held output beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> ($stable(o_out.pixel_out) && o_out.valid))
        else $error("stalled output changed");

endmodule
